FILE: rtl/core/abf_pkg.sv
`default_nettype none
package abf_pkg;

   localparam int COORD_W    = 12;
   localparam int PIX_W      = 32;
   localparam int CMD_W      = 2;
   localparam int REQ_DATA_W = 56;
   localparam int CHAN_W     = 8;
   localparam int LANES      = 4;
   localparam int ALPHA_LANE = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PLOT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_PLOT  = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              on_screen;
      logic [PIX_W-1:0]  color;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage
`default_nettype wire

FILE: rtl/core/abf_front.sv
`default_nettype none
module abf_front #(
   parameter int SCREEN_COLS = 64,
   parameter int SCREEN_ROWS = 64,
   parameter int AW          = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [abf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [abf_pkg::CMD_W-1:0]       req_tuser,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output abf_pkg::cmd_type                     out_cmd,
   output logic [AW-1:0]                        out_addr
);
   import abf_pkg::*;

   logic [COORD_W-1:0] x;
   logic [COORD_W-1:0] y;
   logic               x_ok;
   logic               y_ok;
   logic               keep;
   logic               accept;
   cmd_type            cmd_now;
   logic [AW-1:0]      addr_now;

   logic               valid_ff, valid_in;
   cmd_type            cmd_ff, cmd_in;
   logic [AW-1:0]      addr_ff, addr_in;

   assign x = req_tdata[COORD_W-1:0];
   assign y = req_tdata[2*COORD_W-1:COORD_W];

   assign x_ok = !x[COORD_W-1] && ({1'b0, x} < (COORD_W+1)'(SCREEN_COLS));
   assign y_ok = !y[COORD_W-1] && ({1'b0, y} < (COORD_W+1)'(SCREEN_ROWS));

   assign addr_now = AW'(AW'(y[COORD_W-2:0]) * AW'(SCREEN_COLS)) + AW'(x[COORD_W-2:0]);

   always_comb begin
      cmd_now.color     = req_tdata[REQ_DATA_W-1:2*COORD_W];
      cmd_now.on_screen = x_ok && y_ok;
      cmd_now.kind      = KIND_CLEAR;
      keep              = 1'b0;
      case (req_tuser)
         CMD_CLEAR: begin
            cmd_now.kind = KIND_CLEAR;
            keep         = 1'b1;
         end
         CMD_PLOT: begin
            cmd_now.kind = KIND_PLOT;
            keep         = x_ok && y_ok;
         end
         CMD_READ: begin
            cmd_now.kind = KIND_READ;
            keep         = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = !valid_ff || out_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      if (accept) begin
         valid_in = keep;
         cmd_in   = cmd_now;
         addr_in  = addr_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
   end

   assign out_valid = valid_ff;
   assign out_cmd   = cmd_ff;
   assign out_addr  = addr_ff;

endmodule
`default_nettype wire

FILE: rtl/core/abf_queue.sv
`default_nettype none
module abf_queue #(
   parameter int W     = 38,
   parameter int DEPTH = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [W-1:0]  push_data,
   input  wire logic          pop,
   output logic [W-1:0]       pop_data,
   output abf_pkg::q_status_type status
);
   import abf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  entry [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PW'(1);
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(DEPTH));

endmodule
`default_nettype wire

FILE: rtl/core/abf_back.sv
`default_nettype none
module abf_back #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire abf_pkg::cmd_type            q_cmd,
   input  wire logic [AW-1:0]               q_addr,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [abf_pkg::PIX_W-1:0]        rsp_tdata,
   output logic                             rsp_tuser
);
   import abf_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_MUL   = 5'b00100,
      S_WRITE = 5'b01000,
      S_READ  = 5'b10000
   } state_type;

   logic [PIX_W-1:0] store_mem [DEPTH];

   state_type        state_ff, state_in;
   logic [AW-1:0]    cnt_ff, cnt_in;
   logic [PIX_W-1:0] fill_ff, fill_in;
   logic [AW-1:0]    op_addr_ff, op_addr_in;
   logic [PIX_W-1:0] op_color_ff, op_color_in;
   logic [PIX_W-1:0] mem_q_ff;
   logic [15:0]      lane_sum_ff [LANES];
   logic [15:0]      lane_sum_in [LANES];
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic             rsp_range_ff, rsp_range_in;

   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [PIX_W-1:0] wr_data;
   logic             out_free;
   logic [PIX_W-1:0] blended;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      logic [15:0] sa;
      logic [15:0] na;
      logic [15:0] sc;
      logic [15:0] dc;
      sa = 16'(op_color_ff[PIX_W-1 -: CHAN_W]);
      na = 16'(8'hFF) - sa;
      for (int i = 0; i < LANES; i++) begin
         sc = (i == ALPHA_LANE) ? 16'(8'hFF) : 16'(op_color_ff[i*CHAN_W +: CHAN_W]);
         dc = 16'(mem_q_ff[i*CHAN_W +: CHAN_W]);
         lane_sum_in[i] = (sa * sc) + (na * dc);
      end
   end

   // floor(v/255) for v <= 255*255
   always_comb begin
      logic [15:0] t;
      for (int i = 0; i < LANES; i++) begin
         t = lane_sum_ff[i] + 16'd1 + (lane_sum_ff[i] >> 8);
         blended[i*CHAN_W +: CHAN_W] = t[15:8];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      op_addr_in   = op_addr_ff;
      op_color_in  = op_color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_range_in = rsp_range_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = q_addr;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = fill_ff;
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (cnt_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               case (q_cmd.kind)
                  KIND_CLEAR: begin
                     q_pop    = 1'b1;
                     fill_in  = q_cmd.color;
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  KIND_PLOT: begin
                     q_pop       = 1'b1;
                     rd_en       = 1'b1;
                     op_addr_in  = q_addr;
                     op_color_in = q_cmd.color;
                     state_in    = S_MUL;
                  end
                  KIND_READ: begin
                     if (q_cmd.on_screen) begin
                        q_pop    = 1'b1;
                        rd_en    = 1'b1;
                        state_in = S_READ;
                     end else if (out_free) begin
                        q_pop        = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_pixel_in = '0;
                        rsp_range_in = 1'b0;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         S_MUL: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = op_addr_ff;
            wr_data  = blended;
            state_in = S_IDLE;
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = mem_q_ff;
               rsp_range_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_addr_ff   <= op_addr_in;
      op_color_ff  <= op_color_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_range_ff <= rsp_range_in;
      if (state_ff == S_MUL) begin
         lane_sum_ff <= lane_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = rsp_range_ff;

endmodule
`default_nettype wire

FILE: rtl/core/alpha_blend_framebuffer.sv
// Frame buffer of SCREEN_COLS x SCREEN_ROWS ARGB8888 pixels with source-over blending.
// req channel: tuser = cmd (clear, plot, read); tdata = x, y, color.
// rsp channel: one beat per read; tdata = pixel, tuser = in_range.
// Pixel (x,y) lives at word y*SCREEN_COLS + x of a single-port store.
// Plots off screen and unused commands are dropped in the front stage.
// A front register and a two-entry queue decouple acceptance from execution,
// so up to three beats are taken while the store is busy or rsp is stalled.
// Back end steps per beat: plot reads, multiplies, then divides and writes (S_IDLE,
// S_MUL, S_WRITE); read reads, then loads the output register (S_IDLE, S_READ);
// clear writes every word in S_CLEAR. A read passes the front register, the queue,
// the store read and the rsp register; a read off screen skips the store read.
// The rate is set by the store's single port: a plot reads then writes it.
// After reset the store is swept to zero, one word a cycle, over all
// SCREEN_COLS*SCREEN_ROWS words; beats queue up meanwhile.
// A stalled rsp holds its beat; reads behind it wait in the queue and
// req_tready drops once the queue and front register are full.
`default_nettype none
module alpha_blend_framebuffer #(
   parameter int SCREEN_COLS = 64,
   parameter int SCREEN_ROWS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // x [11:0], y [23:12], color [55:24]
   input  wire logic [abf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd [1:0]
   input  wire logic [abf_pkg::CMD_W-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // pixel [31:0]
   output logic [abf_pkg::PIX_W-1:0]            rsp_tdata,
   // in_range [0]
   output logic                                 rsp_tuser
);
   import abf_pkg::*;

   localparam int DEPTH = SCREEN_COLS * SCREEN_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QW    = $bits(cmd_type) + AW;

   logic          fr_valid;
   cmd_type       fr_cmd;
   logic [AW-1:0] fr_addr;
   logic          q_push;
   logic          q_pop;
   logic [QW-1:0] q_data;
   q_status_type  q_status;
   cmd_type       bk_cmd;
   logic [AW-1:0] bk_addr;

   abf_front #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS),
      .AW(AW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .out_valid(fr_valid),
      .out_ready(!q_status.full),
      .out_cmd(fr_cmd),
      .out_addr(fr_addr)
   );

   assign q_push = fr_valid && !q_status.full;

   abf_queue #(
      .W(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data({fr_cmd, fr_addr}),
      .pop(q_pop),
      .pop_data(q_data),
      .status(q_status)
   );

   assign bk_cmd  = q_data[QW-1:AW];
   assign bk_addr = q_data[AW-1:0];

   abf_back #(
      .DEPTH(DEPTH),
      .AW(AW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(!q_status.empty),
      .q_cmd(bk_cmd),
      .q_addr(bk_addr),
      .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_push_notfull: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full queue");

   a_offscreen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("off-screen read returned nonzero pixel");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && q_status.empty))
      else $error("state not cleared by reset");

endmodule
`default_nettype wire
